[rtl/rarmt_pkg.sv]
// Shared types and constants for the range-assign / range-minimum tree.
// No dependencies; every other file of the block imports this package.
package rarmt_pkg;

  localparam int unsigned LEAVES_DEF = 1024;
  localparam int unsigned VAL_W      = 31;
  localparam int unsigned IDX_W      = 10;
  localparam logic [VAL_W-1:0] TOP_VALUE = {VAL_W{1'b1}};

  // One tree node word: tag set means every leaf below equals val
  typedef struct packed {
    logic             tag;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] mn;
  } node_t;

  localparam int unsigned NODE_W = $bits(node_t);

  typedef enum logic {
    OP_ASSIGN = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_EVAL  = 5'b01000,
    S_RET   = 5'b10000
  } state_e;

endpackage

[rtl/rarmt_node_ram.sv]
// Single-port-write, single-port-read node memory with registered read data.
// Depends on rarmt_pkg for the node word type.
module rarmt_node_ram import rarmt_pkg::*; #(
  parameter int unsigned DEPTH = 2 * LEAVES_DEF - 1,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  node_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output node_t         rdata_o
);

  node_t mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/range_assign_range_min_tree_unit.sv]
// Lazy segment tree, range assign and range minimum, over LEAVES entries.
// After reset a clearing pass writes all 2*S-1 nodes (S = LEAVES rounded up to a power
// of two) with busy high. An empty range completes from idle without a walk. Otherwise
// the walk takes each visited node through a memory read, an evaluate and a return
// state, one node at a time through the single node memory port; busy stays high and
// no new word is taken until the walk ends.
// A query result appears on range_minimum_o for exactly one cycle with result_valid_o
// high, and the receiver must take it then.
// Depends on rarmt_pkg and rarmt_node_ram.
module range_assign_range_min_tree_unit import rarmt_pkg::*; #(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             operation_i,
  input  logic [IDX_W-1:0] range_start_i,
  input  logic [IDX_W-1:0] range_end_i,
  input  logic [VAL_W-1:0] fill_value_i,
  output logic             result_valid_o,
  output logic [VAL_W-1:0] range_minimum_o
);

  localparam int unsigned LW    = $clog2(LEAVES);
  localparam int unsigned SPAN  = 1 << LW;
  localparam int unsigned NODES = 2 * SPAN - 1;
  localparam int unsigned NW    = $clog2(NODES);
  localparam int unsigned SPW   = $clog2(LW + 1);
  localparam int unsigned STW   = (LW > 1) ? $clog2(LW) : 1;
  localparam int unsigned CW    = ((LW > IDX_W) ? LW : IDX_W) + 1;
  localparam int unsigned RW    = LW + 1;

  typedef struct packed {
    logic [NW-1:0]    k;
    logic [RW-1:0]    nl;
    logic [RW-1:0]    nr;
    logic             right;
    logic             tag;
    logic [VAL_W-1:0] tval;
    logic [VAL_W-1:0] lmin;
  } frame_t;

  state_e state_q, state_d;
  logic [NW-1:0]    clr_q, clr_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic [NW-1:0]    cur_k_q, cur_k_d;
  logic [RW-1:0]    cur_nl_q, cur_nl_d, cur_nr_q, cur_nr_d;
  logic             inh_q, inh_d;
  logic [VAL_W-1:0] iv_q, iv_d;
  logic             op_q, op_d;
  logic [RW-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [VAL_W-1:0] fv_q, fv_d, ret_q, ret_d;
  logic             valid_q, valid_d;
  logic [VAL_W-1:0] rmin_q, rmin_d;
  frame_t           stack_q [LW];

  logic             stk_we;
  logic [STW-1:0]   stk_wa;
  frame_t           stk_wd;
  logic             mem_we, mem_re, descend;
  logic [NW-1:0]    mem_wa;
  node_t            mem_wd, rd_data, rec;
  frame_t           top;
  logic [STW-1:0]   top_idx;
  logic [CW-1:0]    s_ext, e_ext;
  logic             empty, disjoint, covered;
  logic [RW:0]      mid_sum;
  logic [RW-1:0]    cur_mid, top_mid;
  logic [VAL_W-1:0] comb_min;

  rarmt_node_ram #(.DEPTH(NODES), .AW(NW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_wa),
    .wdata_i (mem_wd),
    .re_i    (mem_re),
    .raddr_i (cur_k_q),
    .rdata_o (rd_data)
  );

  // clip the range end and spot an empty range
  always_comb begin
    s_ext = CW'(range_start_i);
    e_ext = CW'(range_end_i);
    if (e_ext >= CW'(LEAVES)) begin
      e_ext = CW'(LEAVES - 1);
    end
    empty = s_ext > e_ext;
  end

  // apply an inherited tag to the node just read
  always_comb begin
    rec = rd_data;
    if (inh_q) begin
      rec = '{tag: 1'b1, val: iv_q, mn: iv_q};
    end
    disjoint = (cur_nr_q <= lo_q) || (hi_q <= cur_nl_q);
    covered  = (lo_q <= cur_nl_q) && (cur_nr_q <= hi_q);
    mid_sum  = (RW + 1)'(cur_nl_q) + (RW + 1)'(cur_nr_q);
    cur_mid  = mid_sum[RW:1];
  end

  // parent frame on top of the stack
  always_comb begin
    top_idx  = STW'(sp_q - SPW'(1));
    top      = stack_q[top_idx];
    top_mid  = RW'(((RW + 1)'(top.nl) + (RW + 1)'(top.nr)) >> 1);
    comb_min = (top.lmin < ret_q) ? top.lmin : ret_q;
  end

  // walk sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    sp_d     = sp_q;
    cur_k_d  = cur_k_q;
    cur_nl_d = cur_nl_q;
    cur_nr_d = cur_nr_q;
    inh_d    = inh_q;
    iv_d     = iv_q;
    op_d     = op_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    fv_d     = fv_q;
    ret_d    = ret_q;
    valid_d  = 1'b0;
    rmin_d   = rmin_q;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_wa   = cur_k_q;
    mem_wd   = rec;
    stk_we   = 1'b0;
    stk_wa   = top_idx;
    stk_wd   = top;
    descend  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '{tag: 1'b0, val: '0, mn: TOP_VALUE};
        clr_d  = clr_q + NW'(1);
        if (clr_q == NW'(NODES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (empty) begin
            valid_d = (operation_i == OP_QUERY);
            rmin_d  = TOP_VALUE;
          end else begin
            op_d     = operation_i;
            lo_d     = RW'(s_ext);
            hi_d     = RW'(e_ext + CW'(1));
            fv_d     = fill_value_i;
            cur_k_d  = '0;
            cur_nl_d = '0;
            cur_nr_d = RW'(SPAN);
            inh_d    = 1'b0;
            sp_d     = '0;
            state_d  = S_READ;
          end
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_RET;
        if (op_q == OP_QUERY) begin
          priority if (disjoint) begin
            ret_d = TOP_VALUE;
          end else if (covered) begin
            ret_d = rec.mn;
          end else if (rec.tag) begin
            ret_d = rec.val;
          end else begin
            descend = 1'b1;
          end
        end else begin
          priority if (disjoint) begin
            mem_we = inh_q;
            ret_d  = rec.mn;
          end else if (covered) begin
            mem_we = 1'b1;
            mem_wd = '{tag: 1'b1, val: fv_q, mn: fv_q};
            ret_d  = fv_q;
          end else begin
            descend = 1'b1;
          end
        end
        // push this node and go to its left child
        if (descend) begin
          stk_we   = 1'b1;
          stk_wa   = STW'(sp_q);
          stk_wd   = '{k: cur_k_q, nl: cur_nl_q, nr: cur_nr_q, right: 1'b0,
                       tag: rec.tag, tval: rec.val, lmin: '0};
          sp_d     = sp_q + SPW'(1);
          cur_k_d  = NW'((cur_k_q << 1) + NW'(1));
          cur_nr_d = cur_mid;
          inh_d    = rec.tag;
          iv_d     = rec.val;
          state_d  = S_READ;
        end
      end
      S_RET: begin
        if (sp_q == '0) begin
          valid_d = (op_q == OP_QUERY);
          rmin_d  = ret_q;
          state_d = S_IDLE;
        end else if (!top.right) begin
          // left child done: hold its minimum, go right
          stk_we       = 1'b1;
          stk_wd.right = 1'b1;
          stk_wd.lmin  = ret_q;
          cur_k_d      = NW'((top.k << 1) + NW'(2));
          cur_nl_d     = top_mid;
          cur_nr_d     = top.nr;
          inh_d        = top.tag;
          iv_d         = top.tval;
          state_d      = S_READ;
        end else begin
          // both children done: combine, write back on an assign, drop the frame
          mem_we = (op_q == OP_ASSIGN);
          mem_wa = top.k;
          mem_wd = '{tag: 1'b0, val: '0, mn: comb_min};
          ret_d  = comb_min;
          sp_d   = sp_q - SPW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      sp_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      sp_q    <= sp_d;
      valid_q <= valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_k_q  <= cur_k_d;
    cur_nl_q <= cur_nl_d;
    cur_nr_q <= cur_nr_d;
    inh_q    <= inh_d;
    iv_q     <= iv_d;
    op_q     <= op_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    fv_q     <= fv_d;
    ret_q    <= ret_d;
    rmin_q   <= rmin_d;
    if (stk_we) begin
      stack_q[stk_wa] <= stk_wd;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign result_valid_o  = valid_q;
  assign range_minimum_o = rmin_q;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(LW)) else $error("walk stack overflow");
  a_no_leaf_descend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL && descend) |-> (cur_nr_q - cur_nl_q > RW'(1)))
    else $error("descent below a leaf");
  a_no_write_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_IDLE) |-> !mem_we)
    else $error("node write outside a write state");
  a_result_after_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($past(state_q) == S_IDLE || $past(state_q) == S_RET))
    else $error("result outside walk end");
`endif

endmodule

[sim/testbench.sv]
// Testbench for range_assign_range_min_tree_unit: range assigns and range-minimum queries.
// Holds a flat array of entries as the predicted contents; depends on rarmt_pkg and the RTL.
module testbench;
  import rarmt_pkg::*;

  localparam int unsigned ENTRIES   = LEAVES_DEF;
  localparam int unsigned IDLE_MAX  = 11;
  localparam int unsigned STALL_LIM = 20000;
  localparam int unsigned DRAIN_CYC = 300;
  localparam int unsigned RAND_WORDS = 1500;

  // Scoreboard: predicted entry contents and the queue of awaited minima
  class minimum_board;
    logic [VAL_W-1:0] entry_val[ENTRIES];
    logic [VAL_W-1:0] awaited_min[$];
    int unsigned      fail_count;

    function new();
      foreach (entry_val[i]) entry_val[i] = TOP_VALUE;
      fail_count = 0;
    endfunction

    // Note an accepted word: apply an assign, or queue the minimum a query yields
    function void note_word(op_e op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                            logic [VAL_W-1:0] fill);
      int unsigned      last;
      logic [VAL_W-1:0] low_val;
      last    = (hi >= ENTRIES) ? ENTRIES - 1 : hi;
      low_val = TOP_VALUE;
      for (int unsigned i = lo; i <= last; i++) begin
        if (op == OP_ASSIGN) entry_val[i] = fill;
        else if (entry_val[i] < low_val) low_val = entry_val[i];
      end
      if (op == OP_QUERY) awaited_min.push_back(low_val);
    endfunction

    // Check a result word against the oldest awaited minimum
    function void check_result(logic [VAL_W-1:0] got);
      logic [VAL_W-1:0] want;
      if (awaited_min.size() == 0) begin
        $error("range_minimum: unexpected result %0d", got);
        fail_count++;
        return;
      end
      want = awaited_min.pop_front();
      if (got !== want) begin
        $error("range_minimum: expected %0d, actual %0d", want, got);
        fail_count++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             operation_i;
  logic [IDX_W-1:0] range_start_i;
  logic [IDX_W-1:0] range_end_i;
  logic [VAL_W-1:0] fill_value_i;
  logic             result_valid_o;
  logic [VAL_W-1:0] range_minimum_o;

  minimum_board sb = new();
  int unsigned  quiet_cycles;

  range_assign_range_min_tree_unit uut (
    .clk_i, .rst_ni, .start, .busy, .operation_i, .range_start_i,
    .range_end_i, .fill_value_i, .result_valid_o, .range_minimum_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Take each result word in the cycle it is shown
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(range_minimum_o);
  end

  // Watchdog: count cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIM) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one word, hold it until taken, then idle for a random gap
  task automatic send_word(op_e op, logic [IDX_W-1:0] lo, logic [IDX_W-1:0] hi,
                           logic [VAL_W-1:0] fill);
    int unsigned gap;
    operation_i   <= op;
    range_start_i <= lo;
    range_end_i   <= hi;
    fill_value_i  <= fill;
    start         <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_word(op, lo, hi, fill);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, IDLE_MAX);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Random word: mostly narrow ranges, some wide and some reversed
  task automatic send_random();
    op_e              op;
    logic [IDX_W-1:0] lo, hi;
    logic [VAL_W-1:0] fill;
    op   = op_e'($urandom_range(0, 1));
    fill = VAL_W'($urandom());
    case ($urandom_range(0, 9))
      0, 1: begin
        lo = IDX_W'($urandom());
        hi = IDX_W'($urandom());
      end
      2: begin
        lo = IDX_W'($urandom());
        hi = IDX_W'(lo - $urandom_range(1, 20));
      end
      default: begin
        lo = IDX_W'($urandom());
        hi = (lo > ENTRIES - 16) ? IDX_W'(ENTRIES - 1)
                                 : IDX_W'(lo + $urandom_range(0, 15));
      end
    endcase
    if ($urandom_range(0, 7) == 0) fill = VAL_W'($urandom_range(0, 15));
    send_word(op, lo, hi, fill);
  endtask

  initial begin
    int unsigned drain;
    rst_ni        = 1'b0;
    start         = 1'b0;
    operation_i   = OP_ASSIGN;
    range_start_i = '0;
    range_end_i   = '0;
    fill_value_i  = '0;
    quiet_cycles  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: untouched tree, extremes of index and value, empty ranges
    send_word(OP_QUERY,  10'd0,    10'd1023, 31'd0);
    send_word(OP_QUERY,  10'd512,  10'd512,  31'd0);
    send_word(OP_ASSIGN, 10'd0,    10'd0,    31'd0);
    send_word(OP_ASSIGN, 10'd1023, 10'd1023, TOP_VALUE);
    send_word(OP_QUERY,  10'd0,    10'd1023, 31'd0);
    send_word(OP_QUERY,  10'd1,    10'd1023, 31'd0);
    send_word(OP_ASSIGN, 10'd0,    10'd1023, 31'h2AAA_AAAA);
    send_word(OP_QUERY,  10'd1023, 10'd1023, 31'd0);
    send_word(OP_ASSIGN, 10'd300,  10'd700,  31'h5555_5555);
    send_word(OP_QUERY,  10'd0,    10'd299,  31'd0);
    send_word(OP_QUERY,  10'd299,  10'd300,  31'd0);
    send_word(OP_ASSIGN, 10'd500,  10'd400,  31'd1);
    send_word(OP_QUERY,  10'd500,  10'd400,  31'd0);
    send_word(OP_QUERY,  10'd1023, 10'd0,    31'd0);
    send_word(OP_ASSIGN, 10'd1,    10'd1022, 31'd7);
    send_word(OP_QUERY,  10'd0,    10'd0,    31'd0);
    send_word(OP_QUERY,  10'd2,    10'd1021, 31'd0);
    send_word(OP_ASSIGN, 10'd255,  10'd256,  31'd3);
    send_word(OP_QUERY,  10'd256,  10'd767,  31'd0);
    send_word(OP_QUERY,  10'd0,    10'd1023, 31'd0);

    // Hold off until every awaited minimum has come back
    start <= 1'b0;
    while (sb.awaited_min.size() != 0) @(posedge clk_i);

    // Random part
    repeat (RAND_WORDS) send_random();
    start <= 1'b0;

    // Drain outstanding results, then let the block settle
    while (sb.awaited_min.size() != 0) @(posedge clk_i);
    for (drain = 0; drain < DRAIN_CYC; drain++) @(posedge clk_i);

    if (sb.fail_count == 0 && sb.awaited_min.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rarmt_pkg.sv
rtl/rarmt_node_ram.sv
rtl/range_assign_range_min_tree_unit.sv
sim/testbench.sv
